>>> hw/rtl/assert_macros.svh
// Assertion macros for the port-level checker of the project.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset cycles included.
`define CHK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/rsi_pkg.sv
// Types, constants and the digit decoder of the radix string to integer parser.
// Used by every module of the block; depends on nothing.
package rsi_pkg;

  localparam int VALUE_BITS_DEF = 56;
  localparam logic [4:0] MAX_RADIX = 5'd16;
  localparam logic [4:0] NO_DIGIT = 5'd16;
  localparam logic [7:0] SIGN_CHAR = 8'h2d;
  localparam logic [4:0] DEC_RADIX = 5'd10;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RADIX    = 2'd1,
    ST_DIGIT    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // One classified character, as it travels from the front to the back.
  typedef struct packed {
    logic       first;
    logic       sign;
    logic [4:0] digit;
    logic [4:0] radix;
    logic       last;
  } item_t;

  // Digit value of a character, or NO_DIGIT when it is not a hex digit.
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h61 + 8'd10);
    end
    return d;
  endfunction

endpackage

>>> hw/rtl/rsi_queue.sv
// Two-entry queue of classified characters between the front and the back.
// Depends on rsi_pkg for the item type.
module rsi_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rsi_pkg::item_t push_item,
  output logic           can_push,
  input  logic           pop,
  output logic           head_valid,
  output rsi_pkg::item_t head_item
);

  rsi_pkg::item_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign can_push   = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hw/rtl/rsi_front.sv
// Front end: accepts input words, decodes the character and tracks literal starts.
// Depends on rsi_pkg for the item type and the digit decoder.
module rsi_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic [4:0]     in_tuser,
  input  logic           in_tlast,
  input  logic           can_push,
  output logic           push,
  output rsi_pkg::item_t push_item
);

  // High when the next word begins a new literal.
  logic at_start_r, at_start_nxt;

  assign in_tready = can_push;
  assign push      = in_tvalid && can_push;

  always_comb begin
    push_item.first = at_start_r;
    push_item.sign  = (in_tdata == rsi_pkg::SIGN_CHAR);
    push_item.digit = rsi_pkg::digit_of(in_tdata);
    push_item.radix = in_tuser;
    push_item.last  = in_tlast;
  end

  always_comb begin
    at_start_nxt = at_start_r;
    if (push) begin
      at_start_nxt = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
    end else begin
      at_start_r <= at_start_nxt;
    end
  end

endmodule

>>> hw/rtl/rsi_back.sv
// Back end: accumulates digits with the overflow check and holds the result word.
// Depends on rsi_pkg for the item type, status codes and radix constants.
module rsi_back #(
  parameter int VALUE_BITS = rsi_pkg::VALUE_BITS_DEF,
  parameter int OUT_W      = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  rsi_pkg::item_t   head_item,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic [1:0]       out_tuser
);

  localparam int PW = VALUE_BITS + 5;
  localparam logic [PW-1:0] LIM_ALL   = {5'd0, {VALUE_BITS{1'b1}}};
  localparam logic [PW-1:0] LIM_NEG10 = PW'(1) << (VALUE_BITS - 1);
  localparam logic [PW-1:0] LIM_POS10 = LIM_NEG10 - PW'(1);

  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  neg_r, neg_nxt;
  logic [4:0]            radix_r, radix_nxt;
  rsi_pkg::status_t      status_r, status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS:0]   out_value_r, out_value_nxt;
  rsi_pkg::status_t      out_status_r, out_status_nxt;

  logic                  can_take;
  logic [VALUE_BITS-1:0] acc_base;
  logic                  neg_base;
  logic [4:0]            radix_eff;
  rsi_pkg::status_t      status_base;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         limit;
  logic [VALUE_BITS:0]   mag;

  // A non-final character never needs the output register.
  assign can_take = !out_valid_r || out_tready;
  assign pop      = head_valid && (!head_item.last || can_take);

  always_comb begin
    acc_base  = head_item.first ? '0 : acc_r;
    neg_base  = head_item.first ? 1'b0 : neg_r;
    radix_eff = head_item.first ? head_item.radix : radix_r;
    if (!head_item.first) begin
      status_base = status_r;
    end else if (head_item.radix < 5'd2 || head_item.radix > rsi_pkg::MAX_RADIX) begin
      status_base = rsi_pkg::ST_RADIX;
    end else begin
      status_base = rsi_pkg::ST_OK;
    end

    prod = PW'(acc_base) * PW'(radix_eff) + PW'(head_item.digit);
    if (radix_eff != rsi_pkg::DEC_RADIX) begin
      limit = LIM_ALL;
    end else if (neg_base) begin
      limit = LIM_NEG10;
    end else begin
      limit = LIM_POS10;
    end

    acc_nxt    = acc_base;
    neg_nxt    = neg_base;
    radix_nxt  = radix_eff;
    status_nxt = status_base;
    if (head_item.first && head_item.sign) begin
      neg_nxt = 1'b1;
    end else if (status_base == rsi_pkg::ST_RADIX) begin
      status_nxt = rsi_pkg::ST_RADIX;
    end else if (head_item.digit >= radix_eff) begin
      status_nxt = rsi_pkg::ST_DIGIT;
    end else if (status_base != rsi_pkg::ST_OK) begin
      status_nxt = status_base;
    end else if (prod > limit) begin
      status_nxt = rsi_pkg::ST_OVERFLOW;
    end else begin
      acc_nxt = prod[VALUE_BITS-1:0];
    end

    if (!pop) begin
      acc_nxt    = acc_r;
      neg_nxt    = neg_r;
      radix_nxt  = radix_r;
      status_nxt = status_r;
    end
  end

  always_comb begin
    mag            = {1'b0, acc_nxt};
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (pop && head_item.last) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_nxt;
      if (status_nxt != rsi_pkg::ST_OK) begin
        out_value_nxt = '0;
      end else if (neg_nxt) begin
        out_value_nxt = ~mag + (VALUE_BITS + 1)'(1);
      end else begin
        out_value_nxt = mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      neg_r       <= 1'b0;
      radix_r     <= 5'd0;
      status_r    <= rsi_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      radix_r     <= radix_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_value_r);
  assign out_tuser  = out_status_r;

endmodule

>>> hw/rtl/radix_string_to_int56.sv
// Top level of the radix string to signed integer parser.
// Depends on rsi_pkg, rsi_front, rsi_queue and rsi_back.
//
// Usage: a literal arrives one character per input word on the in_ stream.
// The radix in in_tuser is taken from the first word of each literal only;
// in_tlast marks its final character. An optional leading '-' negates.
// Exactly one result word leaves on the out_ stream per literal, when its
// last character has been processed: out_tdata carries the signed value
// (zero on any error) and out_tuser the status (ok, bad radix, bad digit,
// overflow, in falling priority).
// Throughput: one character per cycle unless a final character meets a
// full output register; the back end's multiply-add is combinational.
// A final character is queued; its result is then registered for output.
// A two-word queue separates the character decoder from the accumulator,
// and the output register lets the next literal be taken while a result
// waits. If the receiver stalls, characters keep flowing until a final
// character meets a full output register; then the queue fills and
// in_tready falls. Reset (synchronous, active low) empties the queue, drops
// any result and starts a new literal; no clearing pass is needed.
module radix_string_to_int56 #(
  parameter int  VALUE_BITS = rsi_pkg::VALUE_BITS_DEF,
  localparam int OUT_W      = ((VALUE_BITS + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // ch
  input  logic [4:0]       in_tuser,   // radix
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // value (signed, VALUE_BITS+1 bits), zero fill
  output logic [1:0]       out_tuser   // status
);

  logic           can_push;
  logic           push;
  rsi_pkg::item_t push_item;
  logic           pop;
  logic           head_valid;
  rsi_pkg::item_t head_item;

  rsi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .can_push  (can_push),
    .push      (push),
    .push_item (push_item)
  );

  rsi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .can_push   (can_push),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  rsi_back #(
    .VALUE_BITS (VALUE_BITS),
    .OUT_W      (OUT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> hw/rtl/rsi_checker.sv
// Port-level checks of the parser, bound to the top level.
// Depends on assert_macros.svh, rsi_pkg and the ports of radix_string_to_int56.
`include "assert_macros.svh"

module rsi_checker #(
  parameter int VALUE_BITS = 56,
  parameter int OUT_W      = 64
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [1:0]       out_tuser
);

  // A stalled result word must hold.
  `CHK_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // Any error status comes with a zero value.
  `CHK_ASSERT(a_err_zero, out_tvalid && out_tuser != rsi_pkg::ST_OK |-> out_tdata[VALUE_BITS:0] == '0, "error result with non-zero value")

  // Reset leaves no result pending and the input side open.
  `CHK_ASSERT_RST(a_reset, !rst_n |=> !out_tvalid && in_tready, "state after reset not clear")

endmodule

bind radix_string_to_int56 rsi_checker #(
  .VALUE_BITS (VALUE_BITS),
  .OUT_W      (OUT_W)
) u_rsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> bench/rsi_result_checker.sv
// Checker for the radix string to integer parser: watches both streams, predicts
// each result word from the accepted characters and compares it with the block.
// Depends on rsi_pkg for the status codes and character constants.
module rsi_result_checker #(
  parameter int  VALUE_BITS = 56,
  localparam int OUT_W      = ((VALUE_BITS + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [7:0]       in_tdata,   // ch
  input  logic [4:0]       in_tuser,   // radix
  input  logic             in_tlast,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,  // value (signed, VALUE_BITS+1 bits), zero fill
  input  logic [1:0]       out_tuser,  // status
  output int               err_count,
  output int               exp_count,
  output int               res_count,
  output int               bad_count
);

  localparam logic [63:0] MAG_ALL   = (64'd1 << VALUE_BITS) - 64'd1;
  localparam logic [63:0] MAG_NEG10 = 64'd1 << (VALUE_BITS - 1);
  localparam logic [63:0] MAG_POS10 = (64'd1 << (VALUE_BITS - 1)) - 64'd1;

  typedef struct packed {
    logic [OUT_W-1:0] data;
    rsi_pkg::status_t status;
  } int_result_t;

  int_result_t expected_results[$];
  int_result_t want;

  // Running state of the literal being parsed.
  logic [VALUE_BITS-1:0] acc_mag;
  logic                  minus_seen;
  logic                  fresh;
  logic [4:0]            lit_radix;
  rsi_pkg::status_t      lit_status;

  int errs;
  int results;
  int bad_results;

  function automatic logic [4:0] char_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    return 5'd16;
  endfunction

  task automatic restart_literal();
    acc_mag    = '0;
    minus_seen = 1'b0;
    fresh      = 1'b1;
    lit_radix  = '0;
    lit_status = rsi_pkg::ST_OK;
  endtask

  task automatic absorb_digit(input logic [7:0] c);
    logic [4:0]  d;
    logic [63:0] lim;
    d = char_digit(c);
    if (lit_status == rsi_pkg::ST_RADIX) return;
    if (d >= lit_radix) begin
      lit_status = rsi_pkg::ST_DIGIT;
      return;
    end
    // Once overflowed, the magnitude is frozen but digits are still vetted.
    if (lit_status != rsi_pkg::ST_OK) return;
    if (lit_radix != rsi_pkg::DEC_RADIX) lim = MAG_ALL;
    else if (minus_seen) lim = MAG_NEG10;
    else lim = MAG_POS10;
    if (64'(acc_mag) > (lim - 64'(d)) / 64'(lit_radix)) begin
      lit_status = rsi_pkg::ST_OVERFLOW;
      return;
    end
    acc_mag = VALUE_BITS'(64'(acc_mag) * 64'(lit_radix) + 64'(d));
  endtask

  task automatic close_literal();
    int_result_t r;
    logic [VALUE_BITS:0] v;
    if (lit_status != rsi_pkg::ST_OK) v = '0;
    else if (minus_seen) v = -{1'b0, acc_mag};
    else v = {1'b0, acc_mag};
    r.data   = OUT_W'(v);
    r.status = lit_status;
    expected_results = {expected_results, r};
    restart_literal();
  endtask

  initial begin
    restart_literal();
    errs        = 0;
    results     = 0;
    bad_results = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_literal();
      expected_results.delete();
    end else begin
      // Results are checked before the characters of the same edge are taken.
      if (out_tvalid && out_tready) begin
        results++;
        if (out_tuser != rsi_pkg::ST_OK) bad_results++;
        if (expected_results.size() == 0) begin
          errs++;
          $display("%0t: result word with nothing expected: value %h status %0d",
                   $time, out_tdata, out_tuser);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata !== want.data) begin
            errs++;
            $display("%0t: value mismatch: expected %0d (%h), actual %0d (%h)", $time,
                     $signed(want.data[VALUE_BITS:0]), want.data,
                     $signed(out_tdata[VALUE_BITS:0]), out_tdata);
          end
          if (out_tuser !== want.status) begin
            errs++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (fresh) begin
          fresh      = 1'b0;
          lit_radix  = in_tuser;
          lit_status = (in_tuser < 5'd2 || in_tuser > rsi_pkg::MAX_RADIX) ?
                       rsi_pkg::ST_RADIX : rsi_pkg::ST_OK;
          if (in_tdata == rsi_pkg::SIGN_CHAR) minus_seen = 1'b1;
          else absorb_digit(in_tdata);
        end else begin
          absorb_digit(in_tdata);
        end
        if (in_tlast) close_literal();
      end
    end
    err_count <= errs;
    exp_count <= expected_results.size();
    res_count <= results;
    bad_count <= bad_results;
  end

endmodule

>>> bench/radix_string_to_int56_tb.sv
// Top of the testbench for radix_string_to_int56: clock, reset, character
// stimulus with random stalls on both streams, and the final verdict.
// Depends on rsi_pkg, the block itself and rsi_result_checker.
module radix_string_to_int56_tb;

  localparam int          VALUE_BITS = 56;
  localparam int          OUT_W      = ((VALUE_BITS + 1 + 7) / 8) * 8;
  localparam int unsigned LIMIT      = 200000;
  localparam int          PHASE_LEN  = 200;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;   // ch
  logic [4:0]       in_tuser   = '0;   // radix
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // value (signed, VALUE_BITS+1 bits), zero fill
  logic [1:0]       out_tuser;         // status

  int          err_count;
  int          exp_count;
  int          res_count;
  int          bad_count;
  int          tx_idle = 35;
  int          rx_idle = 53;
  int          chars_sent = 0;
  int          literals_sent = 0;
  int unsigned cycle_count = 0;

  radix_string_to_int56 #(.VALUE_BITS(VALUE_BITS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rsi_result_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .err_count  (err_count),
    .exp_count  (exp_count),
    .res_count  (res_count),
    .bad_count  (bad_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] digit_char(input int unsigned d, input bit upper);
    if (d < 10) return 8'(8'h30 + d);
    return upper ? 8'(8'h41 + d - 10) : 8'(8'h61 + d - 10);
  endfunction

  // A character that is never a digit in the given radix.
  function automatic logic [7:0] bad_char(input int unsigned rdx);
    case ($urandom_range(0, 5))
      0: return 8'h40;           // '@', just below 'A'
      1: return 8'h60;           // grave accent, just below 'a'
      2: return rsi_pkg::SIGN_CHAR;
      3: return "g";
      4: return ":";
      default: return (rdx < 16) ?
                      digit_char($urandom_range(rdx, 15), 1'($urandom_range(0, 1))) : "/";
    endcase
  endfunction

  // Valid stays high from one word to the next unless the sender idles.
  task automatic send_word(input logic [7:0] c, input logic [4:0] rdx, input logic l);
    if ($urandom_range(0, 99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < tx_idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= rdx;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
    if (l) literals_sent++;
  endtask

  // The radix on words after the first is noise that the block must ignore.
  task automatic send_literal(input logic [7:0] txt[$], input logic [4:0] rdx);
    foreach (txt[i]) send_word(txt[i], (i == 0) ? rdx : 5'($urandom), i == txt.size() - 1);
  endtask

  task automatic send_text(input string s, input logic [4:0] rdx);
    logic [7:0] txt[$];
    foreach (s[i]) txt = {txt, s[i]};
    send_literal(txt, rdx);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (exp_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random_literal();
    logic [7:0]  txt[$];
    int unsigned kind;
    int unsigned rdx;
    bit          neg;
    logic [63:0] v;
    kind = $urandom_range(0, 99);
    rdx  = $urandom_range(2, 16);
    neg  = 1'($urandom_range(0, 1));
    if (kind < 10) begin
      // Noise: arbitrary bytes under an arbitrary radix.
      rdx = $urandom_range(0, 31);
      repeat ($urandom_range(1, 4))
        txt = {txt, (($urandom_range(0, 3) == 0) ? rsi_pkg::SIGN_CHAR : 8'($urandom))};
    end else if (kind < 45) begin
      // A magnitude within two of the limit for this radix and sign.
      if ($urandom_range(0, 1)) rdx = 10;
      if (rdx == 10) v = neg ? (64'd1 << (VALUE_BITS - 1)) : (64'd1 << (VALUE_BITS - 1)) - 64'd1;
      else v = (64'd1 << VALUE_BITS) - 64'd1;
      v = v + 64'($urandom_range(0, 4)) - 64'd2;
      do begin
        txt.push_front(digit_char(32'(v % 64'(rdx)), 1'($urandom_range(0, 1))));
        v = v / 64'(rdx);
      end while (v != 0);
      repeat ($urandom_range(0, 2)) txt.push_front("0");
    end else if (kind < 80) begin
      repeat ($urandom_range(1, 6))
        txt = {txt, digit_char($urandom_range(0, rdx - 1), 1'($urandom_range(0, 1)))};
    end else begin
      repeat ($urandom_range(12, 20))
        txt = {txt, digit_char($urandom_range(0, rdx - 1), 1'($urandom_range(0, 1)))};
    end
    if (kind >= 10) begin
      if ($urandom_range(0, 9) == 0) txt[$urandom_range(0, txt.size() - 1)] = bad_char(rdx);
      if (neg) txt.push_front(rsi_pkg::SIGN_CHAR);
    end
    send_literal(txt, 5'(rdx));
  endtask

  initial begin
    logic [7:0] grave[$];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed literals: sign handling, radix range, digit edges and priority.
    send_text("0", 5'd2);
    send_text("-", 5'd10);
    send_text("-", 5'd16);
    send_text("1", 5'd0);
    send_text("1", 5'd1);
    send_text("5", 5'd17);
    send_text("@", 5'd16);
    grave = {grave, 8'h60};
    send_literal(grave, 5'd16);
    send_text("Ff", 5'd16);
    send_text("-aB", 5'd12);
    send_text("1-", 5'd10);
    send_text("2", 5'd2);
    send_text("G", 5'd16);
    send_text("z", 5'd31);
    send_text("9", 5'd9);
    send_text("7", 5'd8);
    send_text("10", 5'd2);

    while (chars_sent < PHASE_LEN / 2) send_random_literal();
    // Let every outstanding result drain before carrying on.
    drain_results();
    while (chars_sent < PHASE_LEN) send_random_literal();

    tx_idle = 53;
    rx_idle = 35;
    while (chars_sent < 2 * PHASE_LEN) send_random_literal();

    tx_idle = 0;
    rx_idle = 0;
    while (chars_sent < 3 * PHASE_LEN) send_random_literal();

    drain_results();
    $display("Sent %0d characters in %0d literals; %0d result words checked,",
             chars_sent, literals_sent, res_count);
    $display("%0d of them with an error status, across three stall patterns.", bad_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
